>>> sv/spq_pkg.sv
// Shared types, codes and constants for the stable priority queue.
package spq_pkg;

  // Widths of the request and result fields.
  localparam int unsigned ValueW  = 32;
  localparam int unsigned PrioW   = 16;
  localparam int unsigned OpW     = 3;
  localparam int unsigned StatusW = 2;
  localparam int unsigned OccW    = 5;

  // Default number of cells in the chain.
  localparam int unsigned DefCapacity = 16;

  // Operation codes carried in the request.
  typedef enum logic [OpW-1:0] {
    OP_INSERT    = 3'd0,
    OP_POP       = 3'd1,
    OP_PEEK      = 3'd2,
    OP_EDIT      = 3'd3,
    OP_DROP_EVEN = 3'd4,
    OP_DROP_ODD  = 3'd5
  } op_e;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // Command broadcast from the controller to every cell.
  typedef enum logic [2:0] {
    CELL_HOLD    = 3'd0,
    CELL_INSERT  = 3'd1,
    CELL_SHIFT   = 3'd2,
    CELL_EDIT    = 3'd3,
    CELL_MARK    = 3'd4,
    CELL_COMPACT = 3'd5
  } cell_op_e;

  typedef struct packed {
    cell_op_e                   code;
    logic signed [ValueW-1:0]   value;
    logic        [PrioW-1:0]    prio;
    logic                       keep_odd;
  } cell_cmd_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_FILTER = 2'b10
  } state_e;

endpackage

>>> sv/spq_cell.sv
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
module spq_cell (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  spq_pkg::cell_cmd_t                   cmd_i,
  input  logic                                 head_i,
  input  logic                                 left_valid_i,
  input  logic                                 left_keep_i,
  input  logic signed [spq_pkg::ValueW-1:0]    left_value_i,
  input  logic        [spq_pkg::PrioW-1:0]     left_prio_i,
  input  logic                                 right_valid_i,
  input  logic signed [spq_pkg::ValueW-1:0]    right_value_i,
  input  logic        [spq_pkg::PrioW-1:0]     right_prio_i,
  output logic signed [spq_pkg::ValueW-1:0]    value_o,
  output logic        [spq_pkg::PrioW-1:0]     prio_o,
  output logic                                 valid_o,
  output logic                                 keep_o
);
  import spq_pkg::*;

  logic signed [ValueW-1:0] value_q, value_d;
  logic        [PrioW-1:0]  prio_q, prio_d;
  logic                     valid_q, valid_d;
  logic                     keep;

  // An entry stays put on insert when it sorts at or before the new one.
  assign keep = valid_q && (prio_q <= cmd_i.prio);

  // Next entry of this slot.
  always_comb begin
    value_d = value_q;
    prio_d  = prio_q;
    valid_d = valid_q;
    unique case (cmd_i.code)
      CELL_INSERT: begin
        if (!keep) begin
          if (left_keep_i) begin
            value_d = cmd_i.value;
            prio_d  = cmd_i.prio;
            valid_d = 1'b1;
          end else begin
            value_d = left_value_i;
            prio_d  = left_prio_i;
            valid_d = left_valid_i;
          end
        end
      end
      CELL_SHIFT: begin
        value_d = right_value_i;
        prio_d  = right_prio_i;
        valid_d = right_valid_i;
      end
      CELL_EDIT: begin
        if (head_i) begin
          value_d = cmd_i.value;
        end
      end
      CELL_MARK: begin
        valid_d = valid_q && (value_q[0] == cmd_i.keep_odd);
      end
      CELL_COMPACT: begin
        // A hole pulls in a live right neighbor; a live entry behind a hole leaves.
        if (!valid_q && right_valid_i) begin
          value_d = right_value_i;
          prio_d  = right_prio_i;
          valid_d = 1'b1;
        end else if (valid_q && !left_valid_i) begin
          valid_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Occupancy flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Entry payload.
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    prio_q  <= prio_d;
  end

  assign value_o = value_q;
  assign prio_o  = prio_q;
  assign valid_o = valid_q;
  assign keep_o  = keep;

endmodule

>>> sv/stable_priority_queue_unit.sv
// Stable priority queue built as a chain of sorted cells with a small controller.
//
// Channel  | Direction | Handshake             | Payload
// s_axis   | in        | tvalid/tready         | tuser: operation; tdata: value, priority
// m_axis   | out       | tvalid/tready         | tuser: status; tdata: head value, occupancy
//
// Insert, pop, peek, edit and unused codes complete on acceptance: every cell moves in the
// same clock edge. The two filters first mark entries, then compact the chain toward
// the head and finally load the result once the result register is free, so the
// input stays closed until that result is loaded.
// A request is taken only while no filter is running and the result register is
// free or being emptied. Reset clears every valid bit; entry payload is not reset.
module stable_priority_queue_unit #(
  parameter int unsigned CAPACITY = spq_pkg::DefCapacity
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // [31:0] item_value, [47:32] item_priority
  input  logic [2:0]  s_axis_tuser_i,   // [2:0] operation
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [31:0] head_value, [36:32] occupancy, zero above
  output logic [1:0]  m_axis_tuser_o    // [1:0] status
);
  import spq_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  // Cell chain signals.
  logic signed [ValueW-1:0] cell_value [CAPACITY];
  logic        [PrioW-1:0]  cell_prio  [CAPACITY];
  logic                     cell_valid [CAPACITY];
  logic                     cell_keep  [CAPACITY];
  cell_cmd_t                cmd;

  state_e               state_q, state_d;
  logic [CntW-1:0]      count_q, count_d;
  logic                 out_valid_q;
  logic signed [ValueW-1:0] out_head_q, res_head;
  status_e              out_status_q, res_status;
  logic [OccW-1:0]      out_occ_q;
  logic                 res_load;
  logic                 out_free;
  logic                 accept;
  op_e                  op;
  logic                 gap_found;
  logic [CntW-1:0]      filt_count;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && out_free;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign op              = op_e'(s_axis_tuser_i);

  // The chain of cells.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic                     l_valid, l_keep, r_valid;
    logic signed [ValueW-1:0] l_value, r_value;
    logic        [PrioW-1:0]  l_prio, r_prio;

    if (g == 0) begin : g_first
      assign l_valid = 1'b1;
      assign l_keep  = 1'b1;
      assign l_value = '0;
      assign l_prio  = '0;
    end else begin : g_mid
      assign l_valid = cell_valid[g-1];
      assign l_keep  = cell_keep[g-1];
      assign l_value = cell_value[g-1];
      assign l_prio  = cell_prio[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign r_valid = 1'b0;
      assign r_value = '0;
      assign r_prio  = '0;
    end else begin : g_inner
      assign r_valid = cell_valid[g+1];
      assign r_value = cell_value[g+1];
      assign r_prio  = cell_prio[g+1];
    end

    spq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd),
      .head_i        (g == 0),
      .left_valid_i  (l_valid),
      .left_keep_i   (l_keep),
      .left_value_i  (l_value),
      .left_prio_i   (l_prio),
      .right_valid_i (r_valid),
      .right_value_i (r_value),
      .right_prio_i  (r_prio),
      .value_o       (cell_value[g]),
      .prio_o        (cell_prio[g]),
      .valid_o       (cell_valid[g]),
      .keep_o        (cell_keep[g])
    );
  end

  // Compaction is finished once no hole sits in front of a live entry;
  // the end of the live run then gives the count.
  always_comb begin
    gap_found  = 1'b0;
    filt_count = '0;
    for (int i = 0; i < CAPACITY - 1; i++) begin
      if (!cell_valid[i] && cell_valid[i+1]) begin
        gap_found = 1'b1;
      end
    end
    for (int i = 0; i < CAPACITY; i++) begin
      if (cell_valid[i] && ((i == CAPACITY - 1) || !cell_valid[(i + 1) % CAPACITY])) begin
        filt_count = filt_count | CntW'(i + 1);
      end
    end
  end

  // Controller: decode the request and drive the chain.
  always_comb begin
    cmd.code     = CELL_HOLD;
    cmd.value    = s_axis_tdata_i[31:0];
    cmd.prio     = s_axis_tdata_i[47:32];
    cmd.keep_odd = (op == OP_DROP_EVEN);
    count_d      = count_q;
    state_d      = state_q;
    res_load     = 1'b0;
    res_head     = '0;
    res_status   = STAT_OK;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_INSERT: begin
              res_load = 1'b1;
              if (count_q == CntW'(CAPACITY)) begin
                res_status = STAT_FULL;
              end else begin
                cmd.code = CELL_INSERT;
                count_d  = count_q + 1'b1;
              end
            end
            OP_POP: begin
              res_load = 1'b1;
              if (count_q == '0) begin
                res_status = STAT_EMPTY;
              end else begin
                res_head = cell_value[0];
                cmd.code = CELL_SHIFT;
                count_d  = count_q - 1'b1;
              end
            end
            OP_PEEK: begin
              res_load = 1'b1;
              if (count_q == '0) begin
                res_status = STAT_EMPTY;
              end else begin
                res_head = cell_value[0];
              end
            end
            OP_EDIT: begin
              res_load = 1'b1;
              if (count_q == '0) begin
                res_status = STAT_EMPTY;
              end else begin
                cmd.code = CELL_EDIT;
              end
            end
            OP_DROP_EVEN, OP_DROP_ODD: begin
              cmd.code = CELL_MARK;
              state_d  = ST_FILTER;
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      ST_FILTER: begin
        cmd.code = CELL_COMPACT;
        if (!gap_found && out_free) begin
          count_d  = filt_count;
          res_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_head_q   <= res_head;
      out_status_q <= res_status;
      out_occ_q    <= OccW'(count_d);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_occ_q, out_head_q};
  assign m_axis_tuser_o  = out_status_q;

endmodule
